>>> design/vehicle_trip_event_monitor_macros.svh
// Assertion macros for the vehicle trip event monitor.
`ifndef VEHICLE_TRIP_EVENT_MONITOR_MACROS_SVH
`define VEHICLE_TRIP_EVENT_MONITOR_MACROS_SVH

// same-cycle implication
`define VTEM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vehicle_trip_event_monitor: assertion failed");

// next-cycle implication
`define VTEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vehicle_trip_event_monitor: assertion failed");

`endif

>>> design/tvem_pkg.sv
// Shared types and constants for the vehicle trip event monitor.
`timescale 1ns / 1ps
package tvem_pkg;

  localparam int unsigned DIST_W_DEFAULT  = 48;
  localparam int unsigned COUNT_W_DEFAULT = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned OUT_TDATA_W = 240;
  localparam int unsigned DIST_OUT_W  = 48;
  localparam int unsigned CNT_OUT_W   = 16;

  localparam int unsigned EV_HARD_BRAKE = 0;
  localparam int unsigned EV_RAPID_ACC  = 1;
  localparam int unsigned EV_STOP_GO    = 2;
  localparam int unsigned EV_SPEEDING   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_SPEED_LIMIT     = 3'd0,
    REG_HARD_BRAKE_DECEL     = 3'd1,
    REG_RAPID_ACCEL_RATE     = 3'd2,
    REG_STOP_GO_SPEED        = 3'd3,
    REG_SPEEDING_SPEED       = 3'd4,
    REG_BRAKE_MIN            = 3'd5,
    REG_RAPID_THROTTLE_MIN   = 3'd6,
    REG_STOP_GO_THROTTLE_MIN = 3'd7
  } cfg_reg_e;

  localparam logic [14:0] RST_IDLE_SPEED_LIMIT     = 15'd100;
  localparam logic [14:0] RST_HARD_BRAKE_DECEL     = 15'd50;
  localparam logic [14:0] RST_RAPID_ACCEL_RATE     = 15'd30;
  localparam logic [14:0] RST_STOP_GO_SPEED        = 15'd1200;
  localparam logic [14:0] RST_SPEEDING_SPEED       = 15'd6000;
  localparam logic [9:0]  RST_BRAKE_MIN            = 10'd200;
  localparam logic [9:0]  RST_RAPID_THROTTLE_MIN   = 10'd250;
  localparam logic [9:0]  RST_STOP_GO_THROTTLE_MIN = 10'd100;

  localparam logic signed [11:0] TEMP_FLOOR = -12'sd400;

  typedef struct packed {
    logic [14:0] idle_speed_limit;
    logic [14:0] hard_brake_decel;
    logic [14:0] rapid_accel_rate;
    logic [14:0] stop_go_speed;
    logic [14:0] speeding_speed;
    logic [9:0]  brake_min;
    logic [9:0]  rapid_throttle_min;
    logic [9:0]  stop_go_throttle_min;
  } cfg_t;

  typedef struct packed {
    logic               trip_start;
    logic [31:0]        time_ms;
    logic [14:0]        speed;
    logic [13:0]        rpm;
    logic [9:0]         brake;
    logic [9:0]         throttle;
    logic signed [11:0] engine_temp;
    logic [15:0]        fuel_level;
  } sample_t;

  typedef struct packed {
    logic [47:0]        distance_sum;
    logic [31:0]        elapsed_ms;
    logic [31:0]        idle_ms;
    logic [14:0]        max_speed;
    logic signed [11:0] max_temp;
    logic [9:0]         peak_throttle;
    logic [15:0]        hard_brakes;
    logic [15:0]        rapid_accels;
    logic [15:0]        stop_go_count;
    logic [15:0]        speeding_count;
    logic [15:0]        fuel_used;
    logic [3:0]         event_now;
  } result_t;

endpackage

>>> design/tvem_cfg_regs.sv
// Threshold configuration registers.
`timescale 1ns / 1ps
module tvem_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tvem_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tvem_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output tvem_pkg::cfg_t                    cfg_o
);

  tvem_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_speed_limit     <= tvem_pkg::RST_IDLE_SPEED_LIMIT;
      cfg_q.hard_brake_decel     <= tvem_pkg::RST_HARD_BRAKE_DECEL;
      cfg_q.rapid_accel_rate     <= tvem_pkg::RST_RAPID_ACCEL_RATE;
      cfg_q.stop_go_speed        <= tvem_pkg::RST_STOP_GO_SPEED;
      cfg_q.speeding_speed       <= tvem_pkg::RST_SPEEDING_SPEED;
      cfg_q.brake_min            <= tvem_pkg::RST_BRAKE_MIN;
      cfg_q.rapid_throttle_min   <= tvem_pkg::RST_RAPID_THROTTLE_MIN;
      cfg_q.stop_go_throttle_min <= tvem_pkg::RST_STOP_GO_THROTTLE_MIN;
    end else if (cfg_we_i) begin
      case (tvem_pkg::cfg_reg_e'(cfg_idx_i))
        tvem_pkg::REG_IDLE_SPEED_LIMIT:     cfg_q.idle_speed_limit     <= cfg_data_i;
        tvem_pkg::REG_HARD_BRAKE_DECEL:     cfg_q.hard_brake_decel     <= cfg_data_i;
        tvem_pkg::REG_RAPID_ACCEL_RATE:     cfg_q.rapid_accel_rate     <= cfg_data_i;
        tvem_pkg::REG_STOP_GO_SPEED:        cfg_q.stop_go_speed        <= cfg_data_i;
        tvem_pkg::REG_SPEEDING_SPEED:       cfg_q.speeding_speed       <= cfg_data_i;
        tvem_pkg::REG_BRAKE_MIN:            cfg_q.brake_min            <= cfg_data_i[9:0];
        tvem_pkg::REG_RAPID_THROTTLE_MIN:   cfg_q.rapid_throttle_min   <= cfg_data_i[9:0];
        tvem_pkg::REG_STOP_GO_THROTTLE_MIN: cfg_q.stop_go_throttle_min <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/tvem_in_stage.sv
// Input register stage for sample words.
`timescale 1ns / 1ps
module tvem_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  tvem_pkg::sample_t s_item_i,
  output logic              valid_o,
  input  logic              pop_i,
  output tvem_pkg::sample_t item_o
);

  logic              vld_q, vld_d;
  tvem_pkg::sample_t item_q;
  logic              take;

  assign s_ready_o = !vld_q || pop_i;
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (pop_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

>>> design/tvem_update.sv
// Trip state update and result register.
`timescale 1ns / 1ps
module tvem_update #(
  parameter int unsigned DISTANCE_WIDTH = tvem_pkg::DIST_W_DEFAULT,
  parameter int unsigned COUNT_WIDTH    = tvem_pkg::COUNT_W_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tvem_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tvem_pkg::sample_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tvem_pkg::result_t out_res_o
);

  localparam int unsigned PROD_W = 48;
  localparam int unsigned SUM_W  = ((DISTANCE_WIDTH > PROD_W) ? DISTANCE_WIDTH : PROD_W) + 1;
  localparam int unsigned DOUT_W = (DISTANCE_WIDTH > tvem_pkg::DIST_OUT_W) ?
                                   DISTANCE_WIDTH : tvem_pkg::DIST_OUT_W;
  localparam int unsigned COUT_W = (COUNT_WIDTH > tvem_pkg::CNT_OUT_W) ?
                                   COUNT_WIDTH : tvem_pkg::CNT_OUT_W;

  logic                      fire;
  logic                      out_vld_q;
  tvem_pkg::result_t         res_q, res_d;

  logic [31:0]               last_time_q, last_time_d;
  logic [14:0]               last_speed_q, last_speed_d;
  logic [3:0]                last_cond_q, last_cond_d;
  logic [DISTANCE_WIDTH-1:0] dist_q, dist_d;
  logic [31:0]               elapsed_q, elapsed_d;
  logic [31:0]               idle_q, idle_d;
  logic [14:0]               speed_pk_q, speed_pk_d;
  logic signed [11:0]        temp_pk_q, temp_pk_d;
  logic [9:0]                thr_pk_q, thr_pk_d;
  logic [COUNT_WIDTH-1:0]    cnt_q [4];
  logic [COUNT_WIDTH-1:0]    cnt_d [4];
  logic [15:0]               start_fuel_q, start_fuel_d;

  logic                      step_ok;
  logic [31:0]               dt;
  logic [15:0]               spd_sum;
  logic [PROD_W-1:0]         dist_inc;
  logic [SUM_W-1:0]          dist_sum;
  logic [32:0]               elapsed_sum, idle_sum;
  logic signed [16:0]        dv;
  logic signed [26:0]        dv_k;
  logic signed [48:0]        dv_ext;
  logic [46:0]               brake_lim, accel_lim;
  logic [3:0]                cond;
  logic [DOUT_W-1:0]         dist_ext;
  logic [COUT_W-1:0]         cnt_ext [4];
  logic [15:0]               cnt_out [4];

  assign in_ready_o = !out_vld_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // datapath
  assign step_ok     = in_item_i.time_ms > last_time_q;
  assign dt          = in_item_i.time_ms - last_time_q;
  assign spd_sum     = {1'b0, last_speed_q} + {1'b0, in_item_i.speed};
  assign dist_inc    = PROD_W'(spd_sum) * PROD_W'(dt);
  assign dist_sum    = SUM_W'(dist_q) + SUM_W'(dist_inc);
  assign elapsed_sum = {1'b0, elapsed_q} + {1'b0, dt};
  assign idle_sum    = {1'b0, idle_q} + {1'b0, dt};

  assign dv        = $signed({2'b00, in_item_i.speed}) - $signed({2'b00, last_speed_q});
  assign dv_k      = dv * 27'sd1000;
  assign dv_ext    = {{22{dv_k[26]}}, dv_k};
  assign brake_lim = 47'(cfg_i.hard_brake_decel) * 47'(dt);
  assign accel_lim = 47'(cfg_i.rapid_accel_rate) * 47'(dt);

  always_comb begin
    cond = '0;
    cond[tvem_pkg::EV_HARD_BRAKE] = ((-dv_ext) >= $signed({2'b00, brake_lim})) &&
                                    (in_item_i.brake >= cfg_i.brake_min);
    cond[tvem_pkg::EV_RAPID_ACC]  = (dv_ext >= $signed({2'b00, accel_lim})) &&
                                    (in_item_i.throttle >= cfg_i.rapid_throttle_min);
    cond[tvem_pkg::EV_STOP_GO]    = (in_item_i.speed < cfg_i.stop_go_speed) &&
                                    (in_item_i.throttle > cfg_i.stop_go_throttle_min);
    cond[tvem_pkg::EV_SPEEDING]   = in_item_i.speed >= cfg_i.speeding_speed;
  end

  always_comb begin
    last_time_d  = in_item_i.time_ms;
    last_speed_d = in_item_i.speed;
    last_cond_d  = last_cond_q;
    dist_d       = dist_q;
    elapsed_d    = elapsed_q;
    idle_d       = idle_q;
    speed_pk_d   = speed_pk_q;
    temp_pk_d    = temp_pk_q;
    thr_pk_d     = thr_pk_q;
    start_fuel_d = start_fuel_q;
    for (int i = 0; i < 4; i++) begin
      cnt_d[i] = cnt_q[i];
    end
    if (in_item_i.trip_start) begin
      last_cond_d  = '0;
      dist_d       = '0;
      elapsed_d    = '0;
      idle_d       = '0;
      speed_pk_d   = in_item_i.speed;
      temp_pk_d    = in_item_i.engine_temp;
      thr_pk_d     = in_item_i.throttle;
      start_fuel_d = in_item_i.fuel_level;
      for (int i = 0; i < 4; i++) begin
        cnt_d[i] = '0;
      end
    end else if (step_ok) begin
      dist_d    = (dist_sum > SUM_W'({DISTANCE_WIDTH{1'b1}})) ? '1
                                                               : dist_sum[DISTANCE_WIDTH-1:0];
      elapsed_d = elapsed_sum[32] ? '1 : elapsed_sum[31:0];
      if ((in_item_i.speed <= cfg_i.idle_speed_limit) && (in_item_i.rpm != '0)) begin
        idle_d = idle_sum[32] ? '1 : idle_sum[31:0];
      end
      for (int i = 0; i < 4; i++) begin
        if (cond[i] && !last_cond_q[i] && (cnt_q[i] != '1)) begin
          cnt_d[i] = cnt_q[i] + COUNT_WIDTH'(1);
        end
      end
      last_cond_d = cond;
      if (in_item_i.speed > speed_pk_q) begin
        speed_pk_d = in_item_i.speed;
      end
      if (in_item_i.engine_temp > temp_pk_q) begin
        temp_pk_d = in_item_i.engine_temp;
      end
      if (in_item_i.throttle > thr_pk_q) begin
        thr_pk_d = in_item_i.throttle;
      end
    end
  end

  // clamp wide internal totals to the output field widths
  assign dist_ext = DOUT_W'(dist_d);
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cnt_ext[i] = COUT_W'(cnt_d[i]);
      cnt_out[i] = (cnt_ext[i] > COUT_W'({tvem_pkg::CNT_OUT_W{1'b1}})) ? '1
                                                                         : cnt_ext[i][15:0];
    end
  end

  always_comb begin
    res_d.distance_sum   = (dist_ext > DOUT_W'({tvem_pkg::DIST_OUT_W{1'b1}})) ? '1
                                                                              : dist_ext[47:0];
    res_d.elapsed_ms     = elapsed_d;
    res_d.idle_ms        = idle_d;
    res_d.max_speed      = speed_pk_d;
    res_d.max_temp       = temp_pk_d;
    res_d.peak_throttle  = thr_pk_d;
    res_d.hard_brakes    = cnt_out[tvem_pkg::EV_HARD_BRAKE];
    res_d.rapid_accels   = cnt_out[tvem_pkg::EV_RAPID_ACC];
    res_d.stop_go_count  = cnt_out[tvem_pkg::EV_STOP_GO];
    res_d.speeding_count = cnt_out[tvem_pkg::EV_SPEEDING];
    res_d.fuel_used      = (start_fuel_d > in_item_i.fuel_level) ?
                           (start_fuel_d - in_item_i.fuel_level) : '0;
    res_d.event_now      = last_cond_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q  <= '0;
      last_speed_q <= '0;
      last_cond_q  <= '0;
      dist_q       <= '0;
      elapsed_q    <= '0;
      idle_q       <= '0;
      speed_pk_q   <= '0;
      temp_pk_q    <= tvem_pkg::TEMP_FLOOR;
      thr_pk_q     <= '0;
      start_fuel_q <= '0;
      for (int i = 0; i < 4; i++) begin
        cnt_q[i] <= '0;
      end
      out_vld_q    <= 1'b0;
      res_q        <= '0;
    end else begin
      if (fire) begin
        last_time_q  <= last_time_d;
        last_speed_q <= last_speed_d;
        last_cond_q  <= last_cond_d;
        dist_q       <= dist_d;
        elapsed_q    <= elapsed_d;
        idle_q       <= idle_d;
        speed_pk_q   <= speed_pk_d;
        temp_pk_q    <= temp_pk_d;
        thr_pk_q     <= thr_pk_d;
        start_fuel_q <= start_fuel_d;
        for (int i = 0; i < 4; i++) begin
          cnt_q[i] <= cnt_d[i];
        end
        res_q        <= res_d;
        out_vld_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q    <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = res_q;

endmodule

>>> design/vehicle_trip_event_monitor.sv
// A sample word is registered in the input stage, its result word in the result register.
// One word per cycle while m_axis_tready holds; the trip update is a single registered pass.
// The input register and the result register each take a new word while handing one on.
// Reset: thresholds return to their defaults, trip totals clear, peak temperature to -40.0 C.
// No clearing pass; the block accepts words in the first cycle after reset is released.
`timescale 1ns / 1ps
`include "vehicle_trip_event_monitor_macros.svh"
module vehicle_trip_event_monitor #(
  parameter int unsigned DISTANCE_WIDTH = tvem_pkg::DIST_W_DEFAULT,
  parameter int unsigned COUNT_WIDTH    = tvem_pkg::COUNT_W_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tvem_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tvem_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // time_ms, speed, rpm, brake, throttle, engine_temp, fuel_level, zero pad
  input  logic [tvem_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // trip_start
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // distance_sum, elapsed_ms, idle_ms, max_speed, max_temp, peak_throttle,
  // hard_brakes, rapid_accels, stop_go_count, speeding_count, fuel_used,
  // event_now, zero pad
  output logic [tvem_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  tvem_pkg::cfg_t    cfg;
  tvem_pkg::sample_t s_item;
  tvem_pkg::sample_t stg_item;
  tvem_pkg::result_t res;
  logic              stg_vld;
  logic              upd_ready;
  logic              upd_fire;

  assign s_item.trip_start  = s_axis_tuser;
  assign s_item.time_ms     = s_axis_tdata[31:0];
  assign s_item.speed       = s_axis_tdata[46:32];
  assign s_item.rpm         = s_axis_tdata[60:47];
  assign s_item.brake       = s_axis_tdata[70:61];
  assign s_item.throttle    = s_axis_tdata[80:71];
  assign s_item.engine_temp = s_axis_tdata[92:81];
  assign s_item.fuel_level  = s_axis_tdata[108:93];

  tvem_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tvem_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .valid_o   (stg_vld),
    .pop_i     (upd_ready),
    .item_o    (stg_item)
  );

  tvem_update #(
    .DISTANCE_WIDTH (DISTANCE_WIDTH),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_upd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (stg_vld),
    .in_ready_o  (upd_ready),
    .in_item_i   (stg_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign upd_fire = stg_vld && upd_ready;

  assign m_axis_tdata = {7'b0, res.event_now, res.fuel_used, res.speeding_count,
                         res.stop_go_count, res.rapid_accels, res.hard_brakes,
                         res.peak_throttle, res.max_temp, res.max_speed, res.idle_ms,
                         res.elapsed_ms, res.distance_sum};

  `VTEM_ASSERT_IMPL(a_empty_stage_ready, clk_i, rst_ni, !stg_vld, s_axis_tready)
  `VTEM_ASSERT_NEXT(a_fire_gives_word, clk_i, rst_ni, upd_fire, m_axis_tvalid)
  `VTEM_ASSERT_NEXT(a_trip_start_clears, clk_i, rst_ni, upd_fire && stg_item.trip_start, res.event_now == 4'h0 && res.hard_brakes == 16'h0 && res.elapsed_ms == 32'h0)
  `VTEM_ASSERT_NEXT(a_distance_monotone, clk_i, rst_ni, upd_fire && !stg_item.trip_start, res.distance_sum >= $past(res.distance_sum))

endmodule

>>> tb/sv/tb_vehicle_trip_event_monitor.sv
// Self-checking testbench for the vehicle trip event monitor, driven with directed and random trips.
`timescale 1ns / 1ps
module tb_vehicle_trip_event_monitor;
  import tvem_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned HOLD_LEN    = 400;
  localparam logic [47:0] DIST_MAX    = '1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  vehicle_trip_event_monitor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // trip model state
  cfg_t               m_cfg;
  logic [31:0]        m_last_time;
  logic [14:0]        m_last_speed;
  logic [3:0]         m_cond;
  logic [47:0]        m_dist;
  logic [31:0]        m_elapsed;
  logic [31:0]        m_idle;
  logic [14:0]        m_speed_pk;
  logic signed [11:0] m_temp_pk;
  logic [9:0]         m_thr_pk;
  logic [15:0]        m_onsets [4];
  logic [15:0]        m_start_fuel;

  result_t     trip_totals_q [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          tx_gaps = 1'b0;
  bit          rx_stalls = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned rx_pick;

  function automatic cfg_t default_thresholds();
    cfg_t c;
    c.idle_speed_limit     = RST_IDLE_SPEED_LIMIT;
    c.hard_brake_decel     = RST_HARD_BRAKE_DECEL;
    c.rapid_accel_rate     = RST_RAPID_ACCEL_RATE;
    c.stop_go_speed        = RST_STOP_GO_SPEED;
    c.speeding_speed       = RST_SPEEDING_SPEED;
    c.brake_min            = RST_BRAKE_MIN;
    c.rapid_throttle_min   = RST_RAPID_THROTTLE_MIN;
    c.stop_go_throttle_min = RST_STOP_GO_THROTTLE_MIN;
    return c;
  endfunction

  function automatic int pick_threshold(int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 30) return hi;
    return $urandom_range(0, hi);
  endfunction

  function automatic cfg_t random_thresholds();
    cfg_t c;
    c.idle_speed_limit     = 15'(pick_threshold(20000));
    c.hard_brake_decel     = 15'(pick_threshold(20000));
    c.rapid_accel_rate     = 15'(pick_threshold(20000));
    c.stop_go_speed        = 15'(pick_threshold(20000));
    c.speeding_speed       = 15'(pick_threshold(20000));
    c.brake_min            = 10'(pick_threshold(1000));
    c.rapid_throttle_min   = 10'(pick_threshold(1000));
    c.stop_go_throttle_min = 10'(pick_threshold(1000));
    return c;
  endfunction

  function automatic void reset_trip_model();
    m_cfg        = default_thresholds();
    m_last_time  = '0;
    m_last_speed = '0;
    m_cond       = '0;
    m_dist       = '0;
    m_elapsed    = '0;
    m_idle       = '0;
    m_speed_pk   = '0;
    m_temp_pk    = TEMP_FLOOR;
    m_thr_pk     = '0;
    foreach (m_onsets[i]) m_onsets[i] = '0;
    m_start_fuel = '0;
  endfunction

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // update trip totals with one accepted sample and return the totals word it produces
  function automatic result_t advance_trip(sample_t s);
    result_t     r;
    logic [31:0] dt;
    logic [63:0] dist_sum;
    longint      d1000;
    longint      dtl;
    logic [3:0]  cond;
    if (s.trip_start) begin
      m_dist       = '0;
      m_elapsed    = '0;
      m_idle       = '0;
      foreach (m_onsets[i]) m_onsets[i] = '0;
      m_cond       = '0;
      m_speed_pk   = s.speed;
      m_temp_pk    = s.engine_temp;
      m_thr_pk     = s.throttle;
      m_start_fuel = s.fuel_level;
    end else if (s.time_ms > m_last_time) begin
      dt       = s.time_ms - m_last_time;
      dist_sum = 64'(m_dist) + (64'(m_last_speed) + 64'(s.speed)) * 64'(dt);
      m_dist   = (dist_sum > 64'(DIST_MAX)) ? DIST_MAX : dist_sum[47:0];
      m_elapsed = sat_add32(m_elapsed, dt);
      if (s.speed <= m_cfg.idle_speed_limit && s.rpm != 0) m_idle = sat_add32(m_idle, dt);
      d1000 = (longint'(s.speed) - longint'(m_last_speed)) * 64'sd1000;
      dtl   = longint'(dt);
      cond[EV_HARD_BRAKE] = (-d1000 >= longint'(m_cfg.hard_brake_decel) * dtl) &&
                            (s.brake >= m_cfg.brake_min);
      cond[EV_RAPID_ACC]  = (d1000 >= longint'(m_cfg.rapid_accel_rate) * dtl) &&
                            (s.throttle >= m_cfg.rapid_throttle_min);
      cond[EV_STOP_GO]    = (s.speed < m_cfg.stop_go_speed) &&
                            (s.throttle > m_cfg.stop_go_throttle_min);
      cond[EV_SPEEDING]   = (s.speed >= m_cfg.speeding_speed);
      for (int i = 0; i < 4; i++) begin
        if (cond[i] && !m_cond[i] && m_onsets[i] != 16'hFFFF) m_onsets[i] = m_onsets[i] + 1'b1;
      end
      m_cond = cond;
      if (s.speed > m_speed_pk) m_speed_pk = s.speed;
      if ($signed(s.engine_temp) > $signed(m_temp_pk)) m_temp_pk = s.engine_temp;
      if (s.throttle > m_thr_pk) m_thr_pk = s.throttle;
    end
    m_last_time  = s.time_ms;
    m_last_speed = s.speed;

    r.distance_sum   = m_dist;
    r.elapsed_ms     = m_elapsed;
    r.idle_ms        = m_idle;
    r.max_speed      = m_speed_pk;
    r.max_temp       = m_temp_pk;
    r.peak_throttle  = m_thr_pk;
    r.hard_brakes    = m_onsets[EV_HARD_BRAKE];
    r.rapid_accels   = m_onsets[EV_RAPID_ACC];
    r.stop_go_count  = m_onsets[EV_STOP_GO];
    r.speeding_count = m_onsets[EV_SPEEDING];
    r.fuel_used      = (m_start_fuel > s.fuel_level) ? m_start_fuel - s.fuel_level : '0;
    r.event_now      = m_cond;
    return r;
  endfunction

  function automatic void queue_totals(result_t r);
    trip_totals_q = {trip_totals_q, r};
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_sample(sample_t s);
    return {3'b0, s.fuel_level, s.engine_temp, s.throttle, s.brake, s.rpm, s.speed, s.time_ms};
  endfunction

  function automatic result_t unpack_totals(logic [OUT_TDATA_W-1:0] d);
    result_t r;
    r.distance_sum   = d[47:0];
    r.elapsed_ms     = d[79:48];
    r.idle_ms        = d[111:80];
    r.max_speed      = d[126:112];
    r.max_temp       = d[138:127];
    r.peak_throttle  = d[148:139];
    r.hard_brakes    = d[164:149];
    r.rapid_accels   = d[180:165];
    r.stop_go_count  = d[196:181];
    r.speeding_count = d[212:197];
    r.fuel_used      = d[228:213];
    r.event_now      = d[232:229];
    return r;
  endfunction

  function automatic sample_t mk_sample(bit start, logic [31:0] t, int v, int rpm, int brake,
                                        int thr, int temp, int fuel);
    sample_t s;
    s.trip_start  = start;
    s.time_ms     = t;
    s.speed       = 15'(v);
    s.rpm         = 14'(rpm);
    s.brake       = 10'(brake);
    s.throttle    = 10'(thr);
    s.engine_temp = 12'(temp);
    s.fuel_level  = 16'(fuel);
    return s;
  endfunction

  function automatic void check_field(string fname, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h actual %0h", fname, e, a);
    end
  endfunction

  function automatic void check_totals(logic [OUT_TDATA_W-1:0] d);
    result_t e;
    result_t a;
    if (trip_totals_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected totals word %0h", d);
      return;
    end
    e = trip_totals_q.pop_front();
    a = unpack_totals(d);
    check_field("distance_sum", e.distance_sum, a.distance_sum);
    check_field("elapsed_ms", e.elapsed_ms, a.elapsed_ms);
    check_field("idle_ms", e.idle_ms, a.idle_ms);
    check_field("max_speed", e.max_speed, a.max_speed);
    check_field("max_temp", 64'(unsigned'(e.max_temp)), 64'(unsigned'(a.max_temp)));
    check_field("peak_throttle", e.peak_throttle, a.peak_throttle);
    check_field("hard_brakes", e.hard_brakes, a.hard_brakes);
    check_field("rapid_accels", e.rapid_accels, a.rapid_accels);
    check_field("stop_go_count", e.stop_go_count, a.stop_go_count);
    check_field("speeding_count", e.speeding_count, a.speeding_count);
    check_field("fuel_used", e.fuel_used, a.fuel_used);
    check_field("event_now", e.event_now, a.event_now);
  endfunction

  // result side: check accepted words, random stalls, long hold-off on request
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_totals(m_axis_tdata);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!rx_stalls) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 75) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left = (rx_pick < 97) ? $urandom_range(0, 3) : $urandom_range(12, 50);
        m_axis_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int tx_gap();
    int r;
    if (!tx_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_sample(sample_t s);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_sample(s);
    s_axis_tuser  <= s.trip_start;
    do @(posedge clk_i); while (!s_axis_tready);
    queue_totals(advance_trip(s));
  endtask

  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (trip_totals_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_thresholds(cfg_t c);
    cfg_reg_e    idx;
    logic [14:0] val;
    settle_idle();
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_e'(i);
      case (idx)
        REG_IDLE_SPEED_LIMIT:     val = c.idle_speed_limit;
        REG_HARD_BRAKE_DECEL:     val = c.hard_brake_decel;
        REG_RAPID_ACCEL_RATE:     val = c.rapid_accel_rate;
        REG_STOP_GO_SPEED:        val = c.stop_go_speed;
        REG_SPEEDING_SPEED:       val = c.speeding_speed;
        REG_BRAKE_MIN:            val = 15'(c.brake_min);
        REG_RAPID_THROTTLE_MIN:   val = 15'(c.rapid_throttle_min);
        REG_STOP_GO_THROTTLE_MIN: val = 15'(c.stop_go_throttle_min);
        default:                  val = '0;
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= val;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    m_cfg = c;
  endtask

  function automatic int rnd_pedal();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 60) return 1000;
    return $urandom_range(0, 1000);
  endfunction

  function automatic int clamp_int(int x, int lo, int hi);
    return (x < lo) ? lo : (x > hi) ? hi : x;
  endfunction

  // one trip: start word, then mostly forward steps with a wandering speed
  task automatic drive_trip(int len);
    logic [31:0] t;
    int v, temp, fuel, rpm, r;
    t    = $urandom;
    v    = $urandom_range(0, 20000);
    temp = int'($urandom_range(0, 1900)) - 400;
    fuel = $urandom_range(0, 65535);
    send_sample(mk_sample(1'b1, t, v, $urandom_range(0, 16383), rnd_pedal(), rnd_pedal(),
                          temp, fuel));
    repeat (len) begin
      r = $urandom_range(0, 99);
      // 80..87 keeps the timestamp: zero step
      if (r < 80) t = t + $urandom_range(1, 2000);
      else if (r >= 88 && r < 93) t = t - $urandom_range(1, 5000);
      else if (r >= 93 && r < 97) t = t + $urandom_range(2001, 100000);
      else if (r >= 97) t = $urandom;
      r = $urandom_range(0, 99);
      if (r < 70) v = v + int'($urandom_range(0, 800)) - 400;
      else if (r < 85) v = v + int'($urandom_range(0, 6000)) - 3000;
      else if (r < 92) v = 0;
      else v = $urandom_range(0, 20000);
      v = clamp_int(v, 0, 20000);
      rpm = (v < 300 && $urandom_range(0, 1)) ? 0 : $urandom_range(0, 16383);
      if ($urandom_range(0, 19) == 0) temp = int'($urandom_range(0, 1900)) - 400;
      else temp = clamp_int(temp + int'($urandom_range(0, 40)) - 20, -400, 1500);
      if ($urandom_range(0, 19) == 0) fuel = $urandom_range(0, 65535);
      else fuel = clamp_int(fuel - int'($urandom_range(0, 5)), 0, 65535);
      send_sample(mk_sample(1'b0, t, v, rpm, rnd_pedal(), rnd_pedal(), temp, fuel));
    end
  endtask

  task automatic run_random_traffic(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(5, 40);
        drive_trip(len);
        sent += len + 1;
      end else begin
        send_sample(mk_sample($urandom_range(0, 9) == 0, $urandom, $urandom_range(0, 20000),
                              $urandom_range(0, 16383), $urandom_range(0, 1000),
                              $urandom_range(0, 1000), int'($urandom_range(0, 1900)) - 400,
                              $urandom_range(0, 65535)));
        sent++;
      end
    end
  endtask

  task automatic test_no_trip_start();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_sample(mk_sample(1'b0, 100, 500, 800, 0, 300, 200, 5000));
    send_sample(mk_sample(1'b0, 100, 20000, 0, 1000, 1000, 1500, 65535));
    send_sample(mk_sample(1'b0, 40, 0, 0, 0, 0, -400, 0));
  endtask

  task automatic test_trip_basics();
    send_sample(mk_sample(1'b1, 1000, 0, 0, 0, 0, -400, 65535));
    send_sample(mk_sample(1'b0, 2000, 20000, 16383, 0, 1000, 1500, 0));
    send_sample(mk_sample(1'b0, 2500, 0, 700, 1000, 1000, -1, 30000));
    send_sample(mk_sample(1'b0, 3000, 0, 1, 0, 0, 0, 30000));
    send_sample(mk_sample(1'b0, 3000, 5000, 0, 0, 0, 0, 0));
    send_sample(mk_sample(1'b1, 10, 100, 50, 0, 0, 20, 100));
    // fuel above the starting level
    send_sample(mk_sample(1'b0, 20, 100, 50, 0, 0, 20, 200));
  endtask

  task automatic test_accumulator_saturation();
    cfg_t c;
    c = default_thresholds();
    c.idle_speed_limit = 15'd20000;
    load_thresholds(c);
    send_sample(mk_sample(1'b1, 0, 20000, 1, 0, 0, 0, 1000));
    send_sample(mk_sample(1'b0, 32'hFFFF_FFFF, 20000, 1, 0, 0, 0, 1000));
    send_sample(mk_sample(1'b0, 0, 20000, 1, 0, 0, 0, 1000));
    send_sample(mk_sample(1'b0, 32'hFFFF_FFFF, 20000, 1, 0, 0, 0, 1000));
    send_sample(mk_sample(1'b0, 32'hFFFF_FFFF, 20000, 1, 0, 0, 0, 1000));
  endtask

  task automatic test_zero_thresholds();
    load_thresholds('0);
    send_sample(mk_sample(1'b1, 500, 3000, 100, 0, 0, 0, 0));
    // equal speeds with zero thresholds: hard brake and rapid accel together
    send_sample(mk_sample(1'b0, 600, 3000, 100, 0, 0, 0, 0));
    send_sample(mk_sample(1'b0, 700, 2000, 0, 0, 0, 0, 0));
    send_sample(mk_sample(1'b0, 800, 2000, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_phase(cfg_t c, int n_items);
    load_thresholds(c);
    tx_gaps   = ($urandom_range(0, 3) != 0);
    rx_stalls = ($urandom_range(0, 3) != 0);
    run_random_traffic(n_items);
  endtask

  task automatic test_backpressure();
    load_thresholds(random_thresholds());
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    hold_req++;
    run_random_traffic(40);
  endtask

  task automatic test_onset_counting();
    load_thresholds(default_thresholds());
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_sample(mk_sample(1'b1, 0, 0, 1000, 1000, 1000, 0, 1000));
    // every condition rises once per pair of words
    for (int i = 1; i <= 24; i++) begin
      send_sample(mk_sample(1'b0, i, (i % 2) ? 7000 : 0, 1000, 1000, 1000, 0, 1000));
    end
  endtask

  initial begin
    reset_trip_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_trip_start();
    test_trip_basics();
    test_accumulator_saturation();
    test_zero_thresholds();
    test_random_phase(default_thresholds(), 500);
    test_random_phase('{15'd20000, 15'd20000, 15'd20000, 15'd20000, 15'd20000,
                        10'd1000, 10'd1000, 10'd1000}, 300);
    test_random_phase(random_thresholds(), 350);
    test_random_phase(random_thresholds(), 350);
    test_random_phase(random_thresholds(), 350);
    test_backpressure();
    test_onset_counting();

    settle_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && trip_totals_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> vehicle_trip_event_monitor.f
+incdir+design
design/tvem_pkg.sv
design/tvem_cfg_regs.sv
design/tvem_in_stage.sv
design/tvem_update.sv
design/vehicle_trip_event_monitor.sv
tb/sv/tb_vehicle_trip_event_monitor.sv
